@@ hdl/sps_pkg.sv @@
package sps_pkg;

  // Width of the stored position and of the cycle counter
  localparam int PosBits = 8;
  localparam int OutPosBits = 8;

  typedef logic [PosBits-1:0] pos_t;

  // Item opcodes
  localparam logic [1:0] OpTick   = 2'd0;
  localparam logic [1:0] OpGoto   = 2'd1;
  localparam logic [1:0] OpZero   = 2'd2;
  localparam logic [1:0] OpSetPos = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CfgPhaseHold  = 2'd0;
  localparam logic [1:0] CfgDeadband   = 2'd1;
  localparam logic [1:0] CfgZeroCycles = 2'd2;

  localparam logic [15:0] PhaseHoldRst  = 16'd2000;
  localparam logic [7:0]  DeadbandRst   = 8'd10;
  localparam logic [7:0]  ZeroCyclesRst = 8'd100;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       enable;
    logic       busy_res;
    logic [7:0] position;
    logic       ignored;
  } out_item_t;

  typedef struct packed {
    logic [15:0] phase_hold;
    logic [7:0]  deadband;
    logic [7:0]  zero_cycles;
  } cfg_t;

  // Coil pattern for a phase: reverse 0110,0101,1001,1010; forward 1010,1001,0101,0110
  function automatic logic [3:0] coil_pattern(input logic rev, input logic [1:0] ph);
    logic [3:0] pat;
    case (ph)
      2'd0: pat = rev ? 4'h6 : 4'hA;
      2'd1: pat = rev ? 4'h5 : 4'h9;
      2'd2: pat = rev ? 4'h9 : 4'h5;
      2'd3: pat = rev ? 4'hA : 4'h6;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

@@ hdl/sps_cfg.sv @@
module sps_cfg
  import sps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_hold  <= PhaseHoldRst;
      cfg_q.deadband    <= DeadbandRst;
      cfg_q.zero_cycles <= ZeroCyclesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPhaseHold:  cfg_q.phase_hold  <= cfg_wdata_i;
        CfgDeadband:   cfg_q.deadband    <= cfg_wdata_i[7:0];
        CfgZeroCycles: cfg_q.zero_cycles <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/sps_engine.sv @@
module sps_engine
  import sps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  pos_t        pos_q, pos_d;
  pos_t        target_q, target_d;
  pos_t        cyc_q, cyc_d;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] hold_q, hold_d;
  logic        rev_q, rev_d;
  logic        sweep_q, sweep_d;
  logic [3:0]  coils_q, coils_d;
  logic        moving_q, moving_d;
  logic        ign;

  pos_t        val;
  logic        go_rev;
  pos_t        diff;
  logic [15:0] limit;
  logic [16:0] hold_nxt;

  always_comb begin
    pos_d    = pos_q;
    target_d = target_q;
    cyc_d    = cyc_q;
    phase_d  = phase_q;
    hold_d   = hold_q;
    rev_d    = rev_q;
    sweep_d  = sweep_q;
    coils_d  = coils_q;
    moving_d = moving_q;
    ign      = 1'b0;

    val      = pos_t'(item_i.value);
    go_rev   = pos_q < val;
    diff     = go_rev ? (val - pos_q) : (pos_q - val);
    limit    = (cfg_i.phase_hold == 16'd0) ? 16'd1 : cfg_i.phase_hold;
    hold_nxt = {1'b0, hold_q} + 17'd1;

    if (item_i.op == OpTick) begin
      if (moving_q) begin
        if (hold_nxt < {1'b0, limit}) begin
          hold_d = hold_nxt[15:0];
        end else begin
          hold_d = 16'd0;
          if (phase_q == 2'd3) begin
            // End of a four-phase cycle: count it down, stop at zero
            phase_d = 2'd0;
            cyc_d   = cyc_q - pos_t'(1);
            if (cyc_d == '0) begin
              moving_d = 1'b0;
              if (!sweep_q) begin
                pos_d = target_q;
              end
            end else begin
              coils_d = coil_pattern(rev_q, 2'd0);
            end
          end else begin
            phase_d = phase_q + 2'd1;
            coils_d = coil_pattern(rev_q, phase_q + 2'd1);
          end
        end
      end
    end else if (moving_q) begin
      ign = 1'b1;
    end else begin
      case (item_i.op)
        OpGoto: begin
          if (diff >= pos_t'(cfg_i.deadband)) begin
            target_d = val;
            if (diff == '0) begin
              pos_d = val;
            end else begin
              rev_d    = go_rev;
              sweep_d  = 1'b0;
              cyc_d    = diff;
              phase_d  = 2'd0;
              hold_d   = 16'd0;
              coils_d  = coil_pattern(go_rev, 2'd0);
              moving_d = 1'b1;
            end
          end
        end
        OpZero: begin
          if (cfg_i.zero_cycles != 8'd0) begin
            rev_d    = 1'b0;
            sweep_d  = 1'b1;
            cyc_d    = pos_t'(cfg_i.zero_cycles);
            phase_d  = 2'd0;
            hold_d   = 16'd0;
            coils_d  = coil_pattern(1'b0, 2'd0);
            moving_d = 1'b1;
          end
        end
        OpSetPos: pos_d = val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      target_q <= '0;
      cyc_q    <= '0;
      phase_q  <= 2'd0;
      hold_q   <= 16'd0;
      rev_q    <= 1'b0;
      sweep_q  <= 1'b0;
      coils_q  <= 4'd0;
      moving_q <= 1'b0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      target_q <= target_d;
      cyc_q    <= cyc_d;
      phase_q  <= phase_d;
      hold_q   <= hold_d;
      rev_q    <= rev_d;
      sweep_q  <= sweep_d;
      coils_q  <= coils_d;
      moving_q <= moving_d;
    end
  end

  assign res_o.coils    = coils_d;
  assign res_o.enable   = moving_d;
  assign res_o.busy_res = moving_d;
  assign res_o.position = pos_d[OutPosBits-1:0];
  assign res_o.ignored  = ign;

endmodule

@@ hdl/stepper_position_sequencer_core.sv @@
// Path from input transaction to result: the input register, then the result register.
// Throughput: one item per cycle unless the output stalls; state update is combinational.
// The input register holds one item while a finished result waits on a stalled output.
// Reset (rst_ni low, asynchronous): coils low, idle, position zero, registers at
// phase_hold_ticks 2000, deadband 10, zero_cycles 100; both pipeline registers empty.
module stepper_position_sequencer_core
  import sps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t out_q;
  logic      out_vld_q;
  out_item_t res;
  logic      out_free;
  logic      fire;
  logic      in_take;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  sps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sps_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // Result register: load on fire, drain when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_enable_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.enable == out_data_o.busy_res))
    else $error("enable and busy_res disagree");

  a_ignored_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.ignored) |-> out_data_o.busy_res)
    else $error("command flagged ignored while idle");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_stall_i && !in_vld_q) |=> !out_valid_o)
    else $error("result shown twice");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

@@ test/stepper_position_sequencer_core_test.sv @@
module stepper_position_sequencer_core_test
  import sps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int RandItems = 250;
  localparam int LongHold = 300;
  localparam logic [1:0] CfgUnused = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgPhaseHold;
  logic [15:0] cfg_wdata_i = '0;

  stepper_position_sequencer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Motor predictor: settings and state
  logic [15:0] hold_ticks_cfg;
  logic [7:0]  deadband_cfg;
  logic [7:0]  sweep_cycles_cfg;
  pos_t        motor_pos;
  pos_t        goal_pos;
  logic [7:0]  cycles_rem;
  logic [1:0]  phase_no;
  logic [15:0] hold_cnt;
  logic        dir_rev;
  logic        in_sweep;
  logic        running;
  logic [3:0]  coil_q;

  in_item_t  cmd_queue[$];
  out_item_t motor_expect_q[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycle_no = 0;

  // Reverse order walks the forward table backward
  function automatic logic [3:0] phase_coils(logic rev, logic [1:0] ph);
    logic [1:0] k;
    k = rev ? ~ph : ph;
    case (k)
      2'd0: return 4'b1010;
      2'd1: return 4'b1001;
      2'd2: return 4'b0101;
      default: return 4'b0110;
    endcase
  endfunction

  function automatic void begin_run(logic [7:0] n, logic rev, logic sweep);
    dir_rev = rev;
    in_sweep = sweep;
    cycles_rem = n;
    phase_no = 2'd0;
    hold_cnt = '0;
    coil_q = phase_coils(rev, 2'd0);
    running = 1'b1;
  endfunction

  function automatic void advance_tick();
    logic [16:0] lim;
    logic [16:0] nxt;
    lim = (hold_ticks_cfg == 16'd0) ? 17'd1 : {1'b0, hold_ticks_cfg};
    nxt = {1'b0, hold_cnt} + 17'd1;
    if (nxt < lim) begin
      hold_cnt = nxt[15:0];
      return;
    end
    hold_cnt = '0;
    if (phase_no == 2'd3) begin
      phase_no = 2'd0;
      cycles_rem = cycles_rem - 8'd1;
      if (cycles_rem == 8'd0) begin
        running = 1'b0;
        if (!in_sweep) motor_pos = goal_pos;
        return;
      end
    end else begin
      phase_no = phase_no + 2'd1;
    end
    coil_q = phase_coils(dir_rev, phase_no);
  endfunction

  function automatic out_item_t motor_step(in_item_t it);
    out_item_t  r;
    logic       drop;
    logic       up;
    logic [7:0] span;
    drop = 1'b0;
    if (it.op == OpTick) begin
      if (running) advance_tick();
    end else if (running) begin
      drop = 1'b1;
    end else if (it.op == OpGoto) begin
      up = motor_pos < it.value;
      span = up ? it.value - motor_pos : motor_pos - it.value;
      if (span >= deadband_cfg) begin
        goal_pos = it.value;
        if (span == 8'd0) motor_pos = it.value;
        else begin_run(span, up, 1'b0);
      end
    end else if (it.op == OpZero) begin
      if (sweep_cycles_cfg != 8'd0) begin_run(sweep_cycles_cfg, 1'b0, 1'b1);
    end else begin
      motor_pos = it.value;
    end
    r.coils = coil_q;
    r.enable = running;
    r.busy_res = running;
    r.position = motor_pos;
    r.ignored = drop;
    return r;
  endfunction

  // Ticks still needed to finish the current run
  function automatic int ticks_left();
    int h;
    int first;
    if (!running) return 0;
    h = (hold_ticks_cfg == 16'd0) ? 1 : int'(hold_ticks_cfg);
    first = h - int'(hold_cnt);
    if (first < 1) first = 1;
    return first + h * (3 - int'(phase_no) + 4 * (int'(cycles_rem) - 1));
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender
  int tx_wait = 0;
  int calm_tx = 0;
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      tx_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) motor_expect_q.push_back(motor_step(in_data_i));
      if (in_valid_i && in_stall_o) begin
        // hold the stalled transaction
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_valid_i <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        in_data_i <= cmd_queue.pop_front();
        in_valid_i <= 1'b1;
        if (calm_tx > 0) begin
          calm_tx--;
          tx_wait = 0;
        end else begin
          tx_wait = gap_len();
          if ($urandom_range(0, 39) == 0) calm_tx = 80;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver and checker
  int stall_left = 0;
  int calm_rx = 0;
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (motor_expect_q.size() == 0) begin
          $error("unexpected result %h", out_data_o);
          mismatches++;
        end else begin
          want = motor_expect_q.pop_front();
          if (out_data_o.coils !== want.coils) begin
            $error("coils: expected %h, actual %h", want.coils, out_data_o.coils);
            mismatches++;
          end
          if (out_data_o.enable !== want.enable) begin
            $error("enable: expected %b, actual %b", want.enable, out_data_o.enable);
            mismatches++;
          end
          if (out_data_o.busy_res !== want.busy_res) begin
            $error("busy_res: expected %b, actual %b", want.busy_res, out_data_o.busy_res);
            mismatches++;
          end
          if (out_data_o.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, out_data_o.position);
            mismatches++;
          end
          if (out_data_o.ignored !== want.ignored) begin
            $error("ignored: expected %b, actual %b", want.ignored, out_data_o.ignored);
            mismatches++;
          end
        end
        results_seen++;
        // back up the pipeline while the sender keeps offering
        if (results_seen == 600 || results_seen == 2500) stall_left = LongHold;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (calm_rx > 0) begin
        calm_rx--;
        out_stall_i <= 1'b0;
      end else begin
        stall_left = gap_len();
        if ($urandom_range(0, 39) == 0) calm_rx = 80;
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_no++;
    if (cycle_no > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [7:0] value);
    in_item_t it;
    it.op = op;
    it.value = value;
    cmd_queue.push_back(it);
  endtask

  // Wait until every transaction has been answered
  task automatic drain();
    while (cmd_queue.size() != 0 || in_valid_i || motor_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CfgPhaseHold:  hold_ticks_cfg = data;
      CfgDeadband:   deadband_cfg = data[7:0];
      CfgZeroCycles: sweep_cycles_cfg = data[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Ticks with the odd command mixed in; those land while busy
  task automatic send_ticks(int n);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        op = 2'($urandom_range(1, 3));
        send(op, 8'($urandom));
      end
      send(OpTick, 8'($urandom));
    end
  endtask

  task automatic retune();
    int          r;
    logic [15:0] hold;
    logic [7:0]  pick;
    r = $urandom_range(0, 9);
    if (r < 5) hold = 16'd1;
    else if (r < 7) hold = 16'd2;
    else if (r < 8) hold = 16'd0;
    else hold = 16'($urandom_range(3, 4));
    write_reg(CfgPhaseHold, hold);
    r = $urandom_range(0, 9);
    if (r < 4) pick = 8'd0;
    else if (r < 8) pick = 8'($urandom_range(1, 4));
    else if (r < 9) pick = 8'd255;
    else pick = 8'($urandom_range(5, 12));
    write_reg(CfgDeadband, {8'($urandom), pick});
    r = $urandom_range(0, 9);
    if (r < 2) pick = 8'd0;
    else if (r < 8) pick = 8'($urandom_range(1, 3));
    else pick = 8'($urandom_range(4, 8));
    write_reg(CfgZeroCycles, {8'($urandom), pick});
    if ($urandom_range(0, 3) == 0) write_reg(CfgUnused, 16'($urandom));
  endtask

  initial begin : stimulus
    int         live_items;
    int         n;
    int         v;
    int         off;
    logic [1:0] op;
    hold_ticks_cfg = PhaseHoldRst;
    deadband_cfg = DeadbandRst;
    sweep_cycles_cfg = ZeroCyclesRst;
    motor_pos = '0;
    goal_pos = '0;
    cycles_rem = '0;
    phase_no = '0;
    hold_cnt = '0;
    dir_rev = 1'b0;
    in_sweep = 1'b0;
    running = 1'b0;
    coil_q = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: idle tick, moves inside the deadband, zero distance
    send(OpTick, 8'hFF);
    send(OpSetPos, 8'd255);
    send(OpGoto, 8'd250);
    send(OpGoto, 8'd255);
    drain();
    write_reg(CfgPhaseHold, 16'd0);
    write_reg(CfgDeadband, 16'd0);
    write_reg(CfgZeroCycles, 16'd0);
    // zero distance with no deadband, empty sweep, one-cycle forward move
    send(OpGoto, 8'd255);
    send(OpZero, 8'd0);
    send(OpGoto, 8'd254);
    send(OpGoto, 8'd0);
    send(OpZero, 8'd0);
    send(OpSetPos, 8'hAA);
    repeat (4) send(OpTick, 8'd0);
    drain();
    write_reg(CfgZeroCycles, 16'd1);
    write_reg(CfgPhaseHold, 16'd1);
    write_reg(CfgUnused, 16'hFFFF);
    send(OpZero, 8'd0);
    repeat (4) send(OpTick, 8'd0);
    drain();
    // change the hold time in the middle of a move
    write_reg(CfgPhaseHold, 16'd2);
    send(OpSetPos, 8'd0);
    send(OpGoto, 8'd2);
    repeat (3) send(OpTick, 8'd0);
    drain();
    write_reg(CfgPhaseHold, 16'hFFFF);
    repeat (2) send(OpTick, 8'd0);
    drain();
    write_reg(CfgPhaseHold, 16'd1);
    send_ticks(ticks_left());
    drain();

    // Full-range move and a short sweep
    write_reg(CfgDeadband, 16'd255);
    write_reg(CfgZeroCycles, 16'd6);
    send(OpSetPos, 8'd0);
    send(OpGoto, 8'd255);
    drain();
    send_ticks(ticks_left());
    drain();
    send(OpZero, 8'd0);
    drain();
    send_ticks(ticks_left());
    drain();

    live_items = 0;
    retune();
    while (live_items < RandItems) begin
      drain();
      if ($urandom_range(0, 11) == 0) retune();
      if (running) begin
        n = ticks_left();
        // leave some runs unfinished so later commands hit a busy block
        if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
        if (n > RandItems - live_items) n = RandItems - live_items;
        send_ticks(n);
        live_items += n;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            off = $urandom_range(0, (deadband_cfg > 20) ? 3 : int'(deadband_cfg) + 3);
            v = $urandom_range(0, 1) ? int'(motor_pos) + off : int'(motor_pos) - off;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            if (hold_ticks_cfg <= 16'd1 && $urandom_range(0, 24) == 0)
              v = $urandom_range(0, 255);
            send(OpGoto, 8'(v));
            live_items++;
          end
          6: begin
            send(OpZero, 8'($urandom));
            live_items++;
          end
          7: begin
            send(OpSetPos, 8'($urandom));
            live_items++;
          end
          8: begin
            repeat ($urandom_range(1, 6)) begin
              op = 2'($urandom_range(0, 3));
              send(op, 8'($urandom));
            end
          end
          default: begin
            repeat ($urandom_range(1, 3)) send(OpTick, 8'($urandom));
          end
        endcase
      end
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0 && motor_expect_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ stepper_position_sequencer_core.f @@
hdl/sps_pkg.sv
hdl/sps_cfg.sv
hdl/sps_engine.sv
hdl/stepper_position_sequencer_core.sv
test/stepper_position_sequencer_core_test.sv
